// File: design/mdb_pkg.sv
// Shared types and constants of the multi-drop bus master engine.
`default_nettype none

package mdb_pkg;

  // Operation codes on the request channel
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_SEND  = 3'd1;
  localparam logic [2:0] OP_RX    = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Bus bytes and status decode constants
  localparam logic [7:0] FILL_BYTE    = 8'hFF;
  localparam logic [7:0] ACK_BYTE     = 8'h00;
  localparam logic [7:0] ST_NONE      = 8'h00;
  localparam logic [7:0] ST_BUSY      = 8'h03;
  localparam logic [7:0] ST_MAX_CODE  = 8'h0C;
  localparam logic [7:0] UNKNOWN_NOTE = 8'h10;
  localparam logic [6:0] NOTE_COUNT   = 7'd5;
  localparam logic [7:0] NOTE_10      = 8'd10;
  localparam logic [7:0] NOTE_20      = 8'd20;
  localparam logic [7:0] NOTE_50      = 8'd50;
  localparam logic [7:0] NOTE_100     = 8'd100;
  localparam logic [7:0] NOTE_200     = 8'd200;

  // Classified command handed from the front end to the engine
  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_SEND,
    CMD_RX,
    CMD_TICK,
    CMD_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [5:0]  idx;    // buffer entry (write/read)
    logic [7:0]  data;   // write value, address byte or received byte
    logic [5:0]  count;  // send count, already clamped
    logic        flag;   // rx: mode bit; read: index in range
  } cmd_t;

endpackage

`default_nettype wire

// File: design/mdb_ifs.sv
// Channel interfaces: request, result and configuration write.
`default_nettype none

interface mdb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [5:0] index;
  logic [7:0] value;
  logic [7:0] address;
  logic [5:0] count;
  logic [7:0] rx_byte;
  logic       rx_mode;

  modport source (output valid, op, index, value, address, count, rx_byte, rx_mode,
                  input ready);
  modport sink   (input valid, op, index, value, address, count, rx_byte, rx_mode,
                  output ready);
endinterface

interface mdb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] tx_byte;
  logic       tx_mode;
  logic [7:0] read_data;
  logic [5:0] received_count;
  logic       timed_out;
  logic [7:0] credit;
  logic       error_flag;
  logic       last;

  modport source (output valid, kind, tx_byte, tx_mode, read_data, received_count,
                  timed_out, credit, error_flag, last,
                  input ready);
  modport sink   (input valid, kind, tx_byte, tx_mode, read_data, received_count,
                  timed_out, credit, error_flag, last,
                  output ready);
endinterface

interface mdb_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: design/mdb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 36
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/mdb_front.sv
// Front end: accepts requests, drops no-op ones and classifies the rest into commands.
`default_nettype none

module mdb_front
  import mdb_pkg::*;
#(
  parameter int BUF_DEPTH = 36
) (
  mdb_in_if.sink     in_ch,
  input  wire logic  q_full,
  output      logic  push,
  output      cmd_t  cmd
);

  localparam int LastIdx = BUF_DEPTH - 1;

  logic idx_ok;
  logic keep;

  assign in_ch.ready = !q_full;
  assign idx_ok      = int'(in_ch.index) < BUF_DEPTH;

  // Classify the request
  always_comb begin
    keep      = 1'b1;
    cmd.op    = CMD_TICK;
    cmd.idx   = in_ch.index;
    cmd.data  = in_ch.value;
    cmd.count = (int'(in_ch.count) > LastIdx) ? 6'(LastIdx) : in_ch.count;
    cmd.flag  = 1'b0;
    case (in_ch.op)
      OP_WRITE: begin
        cmd.op = CMD_WRITE;
        keep   = idx_ok;    // out-of-range writes vanish
      end
      OP_SEND: begin
        cmd.op   = CMD_SEND;
        cmd.data = in_ch.address;
      end
      OP_RX: begin
        cmd.op   = CMD_RX;
        cmd.data = in_ch.rx_byte;
        cmd.flag = in_ch.rx_mode;
      end
      OP_TICK: begin
        cmd.op = CMD_TICK;
      end
      OP_READ: begin
        cmd.op   = CMD_READ;
        cmd.flag = idx_ok;
      end
      default: begin
        keep = 1'b0;        // unknown op
      end
    endcase
  end

  assign push = in_ch.valid && in_ch.ready && keep;

endmodule

`default_nettype wire

// File: design/mdb_queue.sv
// Two-entry command queue between front end and engine.
`default_nettype none

module mdb_queue
  import mdb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output      logic full,
  input  wire logic pop,
  output      cmd_t pop_cmd,
  output      logic nonempty
);

  cmd_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign pop_cmd  = slot_r[rptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop  ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: design/mdb_back.sv
// Engine: runs commands against the message buffer and drives the result register.
`default_nettype none

module mdb_back
  import mdb_pkg::*;
#(
  parameter int BUF_DEPTH = 36
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic        cmd_valid,
  output      logic        cmd_pop,
  input  wire logic [15:0] timeout_ticks,
  mdb_out_if.source        out_ch
);

  localparam int AW      = $clog2(BUF_DEPTH);
  localparam int CW      = $clog2(BUF_DEPTH + 1);
  localparam int LastIdx = BUF_DEPTH - 1;
  localparam int CntMax  = 63;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEND_ADDR,
    ST_SEND_DATA,
    ST_SEND_SUM,
    ST_FILL,
    ST_READ,
    ST_ACK,
    ST_CMP_RD,
    ST_CMP_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       tx_mode;
    logic [7:0] read_data;
    logic [5:0] received_count;
    logic       timed_out;
    logic [7:0] credit;
    logic       error_flag;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] credit;
    logic       err;
  } status_t;

  // Status byte decode; err_in is the sticky flag before this reply
  function automatic status_t decode_status(input logic [7:0] b, input logic err_in);
    status_t s;
    s.credit = 8'd0;
    s.err    = err_in;
    if (b[7]) begin
      case (b[6:0])
        7'd0:    s.credit = NOTE_10;
        7'd1:    s.credit = NOTE_20;
        7'd2:    s.credit = NOTE_50;
        7'd3:    s.credit = NOTE_100;
        7'd4:    s.credit = NOTE_200;
        default: begin
          s.credit = UNKNOWN_NOTE;
          s.err    = 1'b1;
        end
      endcase
    end else if (b == ST_NONE) begin
      s.credit = 8'd0;
    end else if (b == ST_BUSY) begin
      s.err = 1'b0;
    end else begin
      s.err    = 1'b1;
      s.credit = (b <= ST_MAX_CODE) ? b : 8'd0;
    end
    return s;
  endfunction

  state_t          state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  res_t            res_r, res_nxt;
  logic            receiving_r, receiving_nxt;
  logic [CW-1:0]   rx_idx_r, rx_idx_nxt;
  logic [15:0]     timer_r, timer_nxt;
  logic            sticky_r, sticky_nxt;
  logic [7:0]      addr_r, addr_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [AW-1:0]   k_r, k_nxt;
  logic            has_data_r, has_data_nxt;
  logic [AW-1:0]   fill_r, fill_nxt;
  logic            oob_r, oob_nxt;
  logic            to_r, to_nxt;

  logic            emit_ok;
  logic [15:0]     timer_inc;
  logic [AW-1:0]   slot;
  status_t         st;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_wa, ram_ra;
  logic [7:0]      ram_wd, ram_rd;

  mdb_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  assign emit_ok   = !out_valid_r || out_ch.ready;
  assign timer_inc = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;
  assign slot      = (int'(rx_idx_r) < BUF_DEPTH) ? rx_idx_r[AW-1:0] : AW'(LastIdx);
  assign st        = decode_status(ram_rd, sticky_r);

  // Command sequencing
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    receiving_nxt = receiving_r;
    rx_idx_nxt    = rx_idx_r;
    timer_nxt     = timer_r;
    sticky_nxt    = sticky_r;
    addr_nxt      = addr_r;
    sum_nxt       = sum_r;
    k_nxt         = k_r;
    has_data_nxt  = has_data_r;
    fill_nxt      = fill_r;
    oob_nxt       = oob_r;
    to_nxt        = to_r;
    cmd_pop       = 1'b0;
    ram_we        = 1'b0;
    ram_wa        = '0;
    ram_wd        = '0;
    ram_re        = 1'b0;
    ram_ra        = '0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            CMD_WRITE: begin
              ram_we = 1'b1;
              ram_wa = cmd.idx[AW-1:0];
              ram_wd = cmd.data;
            end
            CMD_READ: begin
              ram_re    = cmd.flag;
              ram_ra    = cmd.idx[AW-1:0];
              oob_nxt   = !cmd.flag;
              state_nxt = ST_READ;
            end
            CMD_SEND: begin
              receiving_nxt = 1'b0;   // abandon any pending reply
              addr_nxt      = cmd.data;
              sum_nxt       = cmd.data;
              k_nxt         = cmd.count[AW-1:0];
              has_data_nxt  = cmd.count != 6'd0;
              state_nxt     = ST_SEND_ADDR;
            end
            CMD_RX: begin
              if (receiving_r) begin
                ram_we    = 1'b1;
                ram_wa    = slot;
                ram_wd    = cmd.data;
                timer_nxt = 16'd0;
                if (int'(rx_idx_r) < BUF_DEPTH) begin
                  rx_idx_nxt = rx_idx_r + CW'(1);
                end
                if (cmd.flag) begin
                  receiving_nxt = 1'b0;
                  to_nxt        = 1'b0;
                  state_nxt     = (cmd.data != ACK_BYTE) ? ST_ACK : ST_CMP_RD;
                end
              end
            end
            CMD_TICK: begin
              if (receiving_r) begin
                timer_nxt = timer_inc;
                if (timer_inc >= timeout_ticks) begin
                  receiving_nxt = 1'b0;
                  to_nxt        = 1'b1;
                  state_nxt     = ST_CMP_RD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Address byte with mode bit, then prefetch the top entry
      ST_SEND_ADDR: begin
        if (emit_ok) begin
          out_valid_nxt   = 1'b1;
          res_nxt         = '0;
          res_nxt.kind    = KIND_TX;
          res_nxt.tx_byte = addr_r;
          res_nxt.tx_mode = 1'b1;
          if (has_data_r) begin
            ram_re    = 1'b1;
            ram_ra    = k_r;
            state_nxt = ST_SEND_DATA;
          end else begin
            state_nxt = ST_SEND_SUM;
          end
        end
      end

      // One buffer entry per cycle while out_ch is not stalled, counting down to entry 0
      ST_SEND_DATA: begin
        if (emit_ok) begin
          out_valid_nxt   = 1'b1;
          res_nxt         = '0;
          res_nxt.kind    = KIND_TX;
          res_nxt.tx_byte = ram_rd;
          sum_nxt         = sum_r + ram_rd;
          if (k_r == '0) begin
            state_nxt = ST_SEND_SUM;
          end else begin
            k_nxt  = k_r - AW'(1);
            ram_re = 1'b1;
            ram_ra = k_r - AW'(1);
          end
        end
      end

      ST_SEND_SUM: begin
        if (emit_ok) begin
          out_valid_nxt   = 1'b1;
          res_nxt         = '0;
          res_nxt.kind    = KIND_TX;
          res_nxt.tx_byte = sum_r;
          res_nxt.last    = 1'b1;
          fill_nxt        = '0;
          state_nxt       = ST_FILL;
        end
      end

      // Sweep the buffer to 0xFF, then open the receive window
      ST_FILL: begin
        ram_we = 1'b1;
        ram_wa = fill_r;
        ram_wd = FILL_BYTE;
        if (fill_r == AW'(LastIdx)) begin
          receiving_nxt = 1'b1;
          rx_idx_nxt    = '0;
          timer_nxt     = 16'd0;
          state_nxt     = ST_IDLE;
        end else begin
          fill_nxt = fill_r + AW'(1);
        end
      end

      ST_READ: begin
        if (emit_ok) begin
          out_valid_nxt     = 1'b1;
          res_nxt           = '0;
          res_nxt.kind      = KIND_READ;
          res_nxt.read_data = oob_r ? 8'd0 : ram_rd;
          res_nxt.last      = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end

      ST_ACK: begin
        if (emit_ok) begin
          out_valid_nxt   = 1'b1;
          res_nxt         = '0;
          res_nxt.kind    = KIND_TX;
          res_nxt.tx_byte = ACK_BYTE;
          res_nxt.tx_mode = 1'b1;
          state_nxt       = ST_CMP_RD;
        end
      end

      // Fetch entry 0 for the status decode
      ST_CMP_RD: begin
        ram_re    = 1'b1;
        ram_ra    = '0;
        state_nxt = ST_CMP_OUT;
      end

      ST_CMP_OUT: begin
        if (emit_ok) begin
          out_valid_nxt          = 1'b1;
          res_nxt                = '0;
          res_nxt.kind           = KIND_DONE;
          res_nxt.received_count = (int'(rx_idx_r) > CntMax) ? 6'(CntMax) : 6'(rx_idx_r);
          res_nxt.timed_out      = to_r;
          res_nxt.credit         = st.credit;
          res_nxt.error_flag     = st.err;
          res_nxt.last           = 1'b1;
          sticky_nxt             = st.err;
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      receiving_r <= 1'b0;
      rx_idx_r    <= '0;
      timer_r     <= 16'd0;
      sticky_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      receiving_r <= receiving_nxt;
      rx_idx_r    <= rx_idx_nxt;
      timer_r     <= timer_nxt;
      sticky_r    <= sticky_nxt;
    end
    res_r      <= res_nxt;
    addr_r     <= addr_nxt;
    sum_r      <= sum_nxt;
    k_r        <= k_nxt;
    has_data_r <= has_data_nxt;
    fill_r     <= fill_nxt;
    oob_r      <= oob_nxt;
    to_r       <= to_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.tx_byte        = res_r.tx_byte;
  assign out_ch.tx_mode        = res_r.tx_mode;
  assign out_ch.read_data      = res_r.read_data;
  assign out_ch.received_count = res_r.received_count;
  assign out_ch.timed_out      = res_r.timed_out;
  assign out_ch.credit         = res_r.credit;
  assign out_ch.error_flag     = res_r.error_flag;
  assign out_ch.last           = res_r.last;

endmodule

`default_nettype wire

// File: design/mdb_master_frame_engine_top.sv
// Top level of the multi-drop bus master frame engine.
//
//   channel  | dir | handshake    | content
//   ---------+-----+--------------+----------------------------------------------
//   in_ch    | in  | valid/ready  | op, index, value, address, count, rx_byte, rx_mode
//   out_ch   | out | valid/ready  | kind, tx_byte, tx_mode, read_data, received_count,
//            |     |              | timed_out, credit, error_flag, last
//   cfg_ch   | in  | valid/ready  | data = timeout_ticks (16 bits), always ready
//
// The front end takes a request per cycle into a two-entry command queue unless it is
// full; the engine runs one command at a time. Write, tick and plain received byte
// run in idle. Read: fetch, then result. Reply end: optional ACK, entry 0 read, result.
// Send: count+3 bus bytes (2 when count is 0; count clamped to BUF_DEPTH-1) at one per
// cycle (the buffer read port) unless out_ch stalls, then a 0xFF sweep of the buffer.
// Reset (rst_n low, synchronous) clears control state; the buffer itself is not cleared.
// A stalled result holds in the output register and only blocks the engine.
`default_nettype none

module mdb_master_frame_engine_top
  import mdb_pkg::*;
#(
  parameter int BUF_DEPTH = 36
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mdb_in_if.sink     in_ch,
  mdb_out_if.source  out_ch,
  mdb_cfg_if.sink    cfg_ch
);

  localparam logic [15:0] TimeoutReset = 16'd5;

  logic [15:0] timeout_r;
  logic        push, q_full, pop, q_nonempty;
  cmd_t        push_cmd, pop_cmd;

  // Configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TimeoutReset;
    end else if (cfg_ch.valid) begin
      timeout_r <= cfg_ch.data;
    end
  end

  mdb_front #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  mdb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .nonempty (q_nonempty)
  );

  mdb_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (pop_cmd),
    .cmd_valid     (q_nonempty),
    .cmd_pop       (pop),
    .timeout_ticks (timeout_r),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire
